@@ hw/rtl/gyro_heading_integrator_top_assert.svh @@
// Assertion macros for the gyro heading integrator top level.
`ifndef GYRO_HEADING_INTEGRATOR_TOP_ASSERT_SVH
`define GYRO_HEADING_INTEGRATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising aclk outside reset.
`define GHI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising aclk outside reset.
`define GHI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ghi_pkg.sv @@
// Shared widths, register indexes and reset values for the gyro heading integrator.
package ghi_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int TS_W       = 32;
    localparam int S_TDATA_W  = 48;
    localparam int HEADING_W  = 48;
    localparam int CAL_CNT_W  = 5;
    localparam int BIAS_W     = 15;
    localparam int RATE_W     = 16;
    localparam int SUM_W      = RATE_W + 1;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_W      = 15;

    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] DEADBAND_RST   = CFG_W'(18);
    localparam logic [CFG_W-1:0] RATE_LIMIT_RST = CFG_W'(5400);

endpackage

@@ hw/rtl/gyro_heading_integrator_top.sv @@
// Gyro heading integrator: bias calibration, rate shaping and trapezoidal integration.
//
//   channel   dir   handshake            payload
//   s_        in    s_tvalid/s_tready    s_tdata: sample, timestamp
//   m_        out   m_tvalid/m_tready    m_tdata: heading; m_tuser: calibrated
//   cfg_      in    cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One item per cycle sustained while m_ is not backpressured; each result passes the
// shaping/dt stage, the 33x17 multiply stage and the accumulate stage into the output
// register.
// Reset (aresetn low, synchronous) clears bias, calibration count, last time, last rate,
// the heading accumulator and all valids, and restores the register defaults.
// Backpressure on m_ stalls each stage only while the stage after it holds data, so
// bubbles are squeezed out; s_tready drops only when all three stages hold data and
// m_tready is low.
`include "gyro_heading_integrator_top_assert.svh"

module gyro_heading_integrator_top
    import ghi_pkg::*;
#(
    parameter int CAL_SAMPLES = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] sample, [41:10] timestamp, [47:42] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [HEADING_W-1:0]  m_tdata,   // [47:0] heading
    output logic                  m_tuser,   // [0] calibrated
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam logic [CAL_CNT_W-1:0] CAL_CNT = CAL_CNT_W'(CAL_SAMPLES);

    // configuration
    logic [CFG_W-1:0] deadband_reg, rate_limit_reg;

    // integrator state
    logic [BIAS_W-1:0]          bias_reg, bias_next;
    logic [CAL_CNT_W-1:0]       cal_count_reg, cal_count_next;
    logic [TS_W-1:0]            last_time_reg, last_time_next;
    logic signed [RATE_W-1:0]   last_rate_reg, last_rate_next;
    logic signed [HEADING_W-1:0] heading_reg;

    // pipeline
    logic                       s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic [TS_W-1:0]            s1_dt_reg, s1_dt_next;
    logic signed [SUM_W-1:0]    s1_sum_reg, s1_sum_next;
    logic                       s1_cal_reg, s1_cal_next, s2_cal_reg, m_cal_reg;
    logic signed [HEADING_W-1:0] s2_prod_reg;

    logic s1_en, s2_en, out_en, s_accept;

    logic [SAMPLE_W-1:0]        sample;
    logic [TS_W-1:0]            timestamp, diff, dt_abs;
    logic [CAL_CNT_W-1:0]       cal_count_inc;
    logic [BIAS_W-1:0]          scaled;
    logic signed [SUM_W-1:0]    rate_raw;
    logic [RATE_W-1:0]          rate_mag;
    logic signed [RATE_W-1:0]   rate_shaped;
    logic signed [TS_W+SUM_W:0] prod_full;

    assign out_en   = !m_valid_reg || m_tready;
    assign s2_en    = !s2_valid_reg || out_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign s_tready = s1_en;
    assign s_accept = s_tvalid && s1_en;

    assign cfg_ready = 1'b1;

    assign sample    = s_tdata[SAMPLE_W-1:0];
    assign timestamp = s_tdata[SAMPLE_W +: TS_W];

    always_comb begin
        cal_count_inc = cal_count_reg + 1'b1;
        scaled   = BIAS_W'(sample) * BIAS_W'(CAL_CNT);
        rate_raw = $signed({2'b00, scaled}) - $signed({2'b00, bias_reg});
        rate_mag = rate_raw[SUM_W-1] ? RATE_W'(-rate_raw) : rate_raw[RATE_W-1:0];

        // deadband first, then clamp
        if (rate_mag < {1'b0, deadband_reg}) begin
            rate_shaped = '0;
        end else if (rate_mag >= {1'b0, rate_limit_reg}) begin
            rate_shaped = rate_raw[SUM_W-1] ? -$signed({1'b0, rate_limit_reg})
                                            : $signed({1'b0, rate_limit_reg});
        end else begin
            rate_shaped = rate_raw[RATE_W-1:0];
        end

        // magnitude of the wrapped difference; zero counts as one
        diff   = timestamp - last_time_reg;
        dt_abs = diff[TS_W-1] ? (~diff + 1'b1) : diff;
        if (dt_abs == '0) begin
            dt_abs = TS_W'(1);
        end

        bias_next      = bias_reg;
        cal_count_next = cal_count_reg;
        last_time_next = last_time_reg;
        last_rate_next = last_rate_reg;
        s1_dt_next     = dt_abs;
        s1_sum_next    = '0;
        s1_cal_next    = 1'b1;

        if (cal_count_reg < CAL_CNT) begin
            bias_next      = bias_reg + BIAS_W'(sample);
            cal_count_next = cal_count_inc;
            s1_cal_next    = (cal_count_inc == CAL_CNT);
            if (cal_count_inc == CAL_CNT) begin
                last_time_next = timestamp;
            end
        end else begin
            s1_sum_next    = SUM_W'(rate_shaped) + SUM_W'(last_rate_reg);
            last_rate_next = rate_shaped;
            last_time_next = timestamp;
        end
    end

    assign prod_full = $signed({1'b0, s1_dt_reg}) * s1_sum_reg;

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg   <= DEADBAND_RST;
            rate_limit_reg <= RATE_LIMIT_RST;
            bias_reg       <= '0;
            cal_count_reg  <= '0;
            last_time_reg  <= '0;
            last_rate_reg  <= '0;
            heading_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_DEADBAND) begin
                    deadband_reg <= cfg_data;
                end else if (cfg_index == REG_RATE_LIMIT) begin
                    rate_limit_reg <= cfg_data;
                end
            end
            if (s_accept) begin
                bias_reg      <= bias_next;
                cal_count_reg <= cal_count_next;
                last_time_reg <= last_time_next;
                last_rate_reg <= last_rate_next;
            end
            if (s1_en) begin
                s1_valid_reg <= s_accept;
            end
            if (s2_en) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en) begin
                m_valid_reg <= s2_valid_reg;
                if (s2_valid_reg) begin
                    heading_reg <= heading_reg + s2_prod_reg;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_dt_reg  <= s1_dt_next;
            s1_sum_reg <= s1_sum_next;
            s1_cal_reg <= s1_cal_next;
        end
        if (s2_en && s1_valid_reg) begin
            s2_prod_reg <= prod_full[HEADING_W-1:0];
            s2_cal_reg  <= s1_cal_reg;
        end
        if (out_en && s2_valid_reg) begin
            m_cal_reg <= s2_cal_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = heading_reg;
    assign m_tuser  = m_cal_reg;

    `GHI_ASSERT_NOW(a_cal_bound, 1'b1, cal_count_reg <= CAL_CNT, "calibration count overran")
    `GHI_ASSERT_NOW(a_cal_flag, m_valid_reg && m_cal_reg, cal_count_reg == CAL_CNT,
                    "calibrated result before calibration finished")
    `GHI_ASSERT_NOW(a_cal_no_step, s1_valid_reg && !s1_cal_reg, s1_sum_reg == '0,
                    "heading step during calibration")
    `GHI_ASSERT_NEXT(a_acc_hold, !(out_en && s2_valid_reg), $stable(heading_reg),
                     "heading changed without a result load")

endmodule
